/* src/ppm_pkg.sv */
// Package for the pulse-period power meter: field widths, ring sizing,
// register indexes, the controller state type and its control struct.
// No dependencies; every other file imports it.
`default_nettype none

package ppm_pkg;

	// Field widths fixed by the interface.
	localparam int TIME_W  = 32;
	localparam int CFG_W   = 24;
	localparam int POWER_W = 32;
	localparam int USED_W  = 4;

	// Ring of recent edge timestamps (valid range 2 to 64).
	localparam int RING_DEPTH = 10;
	localparam int SLOT_W     = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH);

	// Intervals are below 2**31, so the sum grows by the count width.
	localparam int SUM_W = 31 + CNT_W;
	// Numerator is scale * 16 * count.
	localparam int NUM_W = CFG_W + 4 + CNT_W;

	// Configuration register indexes.
	localparam int REG_IDX_W = 2;
	localparam logic [REG_IDX_W-1:0] REG_ENERGY_SCALE = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MIN_POWER    = 2'd1;

	localparam logic [CFG_W-1:0] ENERGY_SCALE_RST = 24'd1500000;
	localparam logic [CFG_W-1:0] MIN_POWER_RST    = 24'd160;

	// Controller states.
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WALK_RD,
		ST_WALK_CHK,
		ST_MUL,
		ST_DIV_GO,
		ST_DIV_WAIT,
		ST_DONE
	} state_t;

	// Decoded controls from the state machine to the datapath.
	typedef struct packed {
		logic in_ready;
		logic walk_take;
		logic mul_load;
		logic div_start;
		logic out_load;
	} ctrl_t;

endpackage

`default_nettype wire

/* src/ppm_if.sv */
// Stream interfaces for the pulse-period power meter: edge input and result output.
// Each carries valid, ready and payload; depends on ppm_pkg for field widths.
`default_nettype none

interface ppm_in_if import ppm_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [TIME_W-1:0] edge_time;

	modport source (output valid, edge_time, input ready);
	modport sink   (input valid, edge_time, output ready);
endinterface

interface ppm_out_if import ppm_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [POWER_W-1:0] power_sixteenths;
	logic               no_data;
	logic [USED_W-1:0]  intervals_used;

	modport source (output valid, power_sixteenths, no_data, intervals_used, input ready);
	modport sink   (input valid, power_sixteenths, no_data, intervals_used, output ready);
endinterface

`default_nettype wire

/* src/ppm_div.sv */
// Bit-serial restoring divider: one quotient bit per clock; the quotient is NUM_W bits wide.
// Depends on ppm_pkg for the numerator and denominator widths.
`default_nettype none

module ppm_div import ppm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [NUM_W-1:0] num,
	input  wire logic [SUM_W-1:0] den,
	output logic                  done,
	output logic      [NUM_W-1:0] quotient
);

	localparam int BIT_W = $clog2(NUM_W + 1);

	logic [SUM_W-1:0] rem_q;
	logic [NUM_W-1:0] quo_q;
	logic [SUM_W-1:0] den_q;
	logic [BIT_W-1:0] bit_q;
	logic             busy_q;
	logic             done_q;

	logic [SUM_W:0]   trial;
	logic [SUM_W:0]   diff;
	logic             fits;

	// Shift the next numerator bit into the partial remainder and try the subtract.
	always_comb begin
		trial = {rem_q, quo_q[NUM_W-1]};
		diff  = trial - {1'b0, den_q};
		fits  = (trial >= {1'b0, den_q});
	end

	// Control: busy flag, bit counter and the completion pulse.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			bit_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				bit_q  <= BIT_W'(NUM_W);
			end else if (busy_q) begin
				bit_q <= bit_q - BIT_W'(1);
				if (bit_q == BIT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Datapath: the quotient shifts in from the right as numerator bits leave.
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= fits ? diff[SUM_W-1:0] : trial[SUM_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], fits};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

/* src/pulse_period_power_meter_core.sv */
// Top level of the pulse-period power meter: edge ring, interval walk and result stage.
// Depends on ppm_pkg, the stream interfaces in ppm_if and the serial divider ppm_div.
`default_nettype none

// Each accepted transaction on pulse is one rising edge of the meter output with
// its microsecond timestamp, and it yields exactly one transaction on result.
// The edge goes into a ring of the RING_DEPTH latest timestamps; the block then
// walks back over valid slots through the ring's registered read port, sums
// the non-negative intervals and divides energy_scale * 16 * count by the sum
// with a one-bit-per-cycle divider. One edge is processed at a time; a
// finished result sits in the output register, so the next edge is accepted
// while it waits. The ring holds no reset; per-slot valid bits cleared at
// reset guard it, so no clearing pass is needed. Configuration writes
// (cfg_index 0 energy_scale, 1 min_power, others ignored) take effect at once
// and are meant to happen only while the block is idle.
module pulse_period_power_meter_core import ppm_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	ppm_in_if.sink                    pulse,
	ppm_out_if.source                 result,
	input  wire logic                 cfg_we,
	input  wire logic [REG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(RING_DEPTH - 1);
	localparam logic [CNT_W:0]    DEPTH_C   = (CNT_W + 1)'(RING_DEPTH);

	// Configuration registers.
	logic [CFG_W-1:0] scale_q;
	logic [CFG_W-1:0] min_q;

	// Ring storage and walk state.
	logic [TIME_W-1:0] ring_mem [RING_DEPTH];
	logic [TIME_W-1:0] rd_q;
	logic [RING_DEPTH-1:0] valid_q;
	logic [SLOT_W-1:0] newest_q;
	logic [SLOT_W-1:0] idx_q;
	logic [TIME_W-1:0] ts_q;
	logic [CNT_W-1:0]  count_q;
	logic [SUM_W-1:0]  sum_q;
	logic [NUM_W-1:0]  num_q;

	// Output register.
	logic               out_valid_q;
	logic [POWER_W-1:0] power_q;
	logic               no_data_q;
	logic [USED_W-1:0]  used_q;

	state_t state_q, state_d;
	ctrl_t  ctrl;

	logic [SLOT_W-1:0]  next_slot;
	logic [SLOT_W-1:0]  prev_idx;
	logic [TIME_W-1:0]  delta;
	logic               walk_go;
	logic               out_free;
	logic               accept;
	logic               div_done;
	logic [NUM_W-1:0]   quotient;
	logic [CFG_W+CNT_W-1:0] prod;
	logic [39:0]        quo_ext;
	logic [POWER_W-1:0] power_raw;
	logic [POWER_W-1:0] power_res;
	logic [7:0]         count_ext;
	logic [USED_W-1:0]  used_res;

	// Slot arithmetic, interval and loop tests.
	always_comb begin
		next_slot = (newest_q == LAST_SLOT) ? '0 : newest_q + SLOT_W'(1);
		prev_idx  = (idx_q == '0) ? LAST_SLOT : idx_q - SLOT_W'(1);
		delta     = ts_q - rd_q;
		walk_go   = (({1'b0, count_q} + (CNT_W + 1)'(1)) < DEPTH_C) && valid_q[idx_q];
		out_free  = !out_valid_q || result.ready;
		accept    = pulse.valid && ctrl.in_ready;
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:     if (pulse.valid) state_d = ST_WALK_RD;
			ST_WALK_RD:  state_d = walk_go ? ST_WALK_CHK : ST_MUL;
			ST_WALK_CHK: state_d = delta[TIME_W-1] ? ST_MUL : ST_WALK_RD;
			ST_MUL:      state_d = (count_q == '0) ? ST_DONE : ST_DIV_GO;
			ST_DIV_GO:   state_d = ST_DIV_WAIT;
			ST_DIV_WAIT: if (div_done) state_d = ST_DONE;
			ST_DONE:     if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// Decoded controls.
	always_comb begin
		ctrl = '0;
		case (state_q)
			ST_IDLE:     ctrl.in_ready  = 1'b1;
			ST_WALK_CHK: ctrl.walk_take = !delta[TIME_W-1];
			ST_MUL:      ctrl.mul_load  = 1'b1;
			ST_DIV_GO:   ctrl.div_start = 1'b1;
			ST_DONE:     ctrl.out_load  = out_free;
			default:     ctrl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= ENERGY_SCALE_RST;
			min_q   <= MIN_POWER_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENERGY_SCALE: scale_q <= cfg_data;
				REG_MIN_POWER:    min_q   <= cfg_data;
				default:          ;
			endcase
		end
	end

	// Valid bits and the newest-slot pointer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			newest_q <= '0;
		end else if (accept) begin
			valid_q[next_slot] <= 1'b1;
			newest_q           <= next_slot;
		end
	end

	// Ring memory: one write port at the new slot, one registered read at the walk index.
	always_ff @(posedge clk) begin
		if (accept) begin
			ring_mem[next_slot] <= pulse.edge_time;
		end
		rd_q <= ring_mem[idx_q];
	end

	// Walk registers: start at the new edge, then step back one slot per taken interval.
	always_ff @(posedge clk) begin
		if (accept) begin
			ts_q    <= pulse.edge_time;
			idx_q   <= (next_slot == '0) ? LAST_SLOT : next_slot - SLOT_W'(1);
			count_q <= '0;
			sum_q   <= '0;
		end else if (ctrl.walk_take) begin
			ts_q    <= rd_q;
			idx_q   <= prev_idx;
			count_q <= count_q + CNT_W'(1);
			sum_q   <= sum_q + SUM_W'(delta[TIME_W-2:0]);
		end
	end

	// Numerator scale * 16 * count, registered ahead of the divider.
	always_comb begin
		prod = {{CNT_W{1'b0}}, scale_q} * {{CFG_W{1'b0}}, count_q};
	end

	always_ff @(posedge clk) begin
		if (ctrl.mul_load) begin
			num_q <= {prod, 4'b0000};
		end
	end

	ppm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (ctrl.div_start),
		.num      (num_q),
		.den      (sum_q),
		.done     (div_done),
		.quotient (quotient)
	);

	// Result: saturate the quotient, treat a zero sum as infinite power, apply the threshold.
	always_comb begin
		quo_ext   = 40'(quotient);
		if (sum_q == '0 || (|quo_ext[39:32])) begin
			power_raw = '1;
		end else begin
			power_raw = quo_ext[31:0];
		end
		power_res = (power_raw < {8'd0, min_q}) ? '0 : power_raw;
		count_ext = 8'(count_q);
		used_res  = (count_ext > 8'd15) ? 4'd15 : count_ext[3:0];
	end

	// Output register: loads when free, holds while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			if (count_q == '0) begin
				power_q   <= '0;
				no_data_q <= 1'b1;
				used_q    <= '0;
			end else begin
				power_q   <= power_res;
				no_data_q <= 1'b0;
				used_q    <= used_res;
			end
		end
	end

	assign pulse.ready             = ctrl.in_ready;
	assign result.valid            = out_valid_q;
	assign result.power_sixteenths = power_q;
	assign result.no_data          = no_data_q;
	assign result.intervals_used   = used_q;

endmodule

`default_nettype wire
